### rtl/hfa_pkg.sv
`timescale 1ns / 1ps
package hfa_pkg;

	// default number of hole entries
	localparam int MAX_HOLES_DEF = 16;

	// field widths
	localparam int SIZE_W   = 16;
	localparam int NUM_W    = 16;
	localparam int SEL_W    = 4;
	localparam int POLICY_W = 2;
	localparam int COUNT_W  = 5;

	// request kinds
	localparam logic KIND_LOAD    = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;

	// fit policies
	localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
	localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
	localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

	// register index, taken from the word address bit
	localparam logic REG_POLICY = 1'b0;
	localparam logic REG_COUNT  = 1'b1;

	typedef struct packed {
		logic              kind;
		logic [SEL_W-1:0]  hole_select;
		logic [SIZE_W-1:0] amount;
	} hfa_in_t;

	typedef struct packed {
		logic [NUM_W-1:0] request_number;
		logic             granted;
		logic [SEL_W-1:0] chosen_hole;
	} hfa_out_t;

	typedef struct packed {
		logic [POLICY_W-1:0] fit_policy;
		logic [COUNT_W-1:0]  hole_count;
	} hfa_cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} hfa_state_t;

endpackage

### rtl/hfa_regs.sv
`timescale 1ns / 1ps
module hfa_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [2:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output hfa_pkg::hfa_cfg_t cfg
);
	import hfa_pkg::*;

	logic [POLICY_W-1:0] policy_q;
	logic [COUNT_W-1:0]  count_q;
	logic                wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= '0;
			count_q  <= '0;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_POLICY: policy_q <= pwdata[POLICY_W-1:0];
				REG_COUNT:  count_q  <= pwdata[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			REG_POLICY: prdata[POLICY_W-1:0] = policy_q;
			REG_COUNT:  prdata[COUNT_W-1:0]  = count_q;
			default: ;
		endcase
	end

	assign cfg.fit_policy = policy_q;
	assign cfg.hole_count = count_q;

endmodule

### rtl/hfa_scan.sv
`timescale 1ns / 1ps
module hfa_scan #(
	parameter int MAX_HOLES = hfa_pkg::MAX_HOLES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  hfa_pkg::hfa_cfg_t cfg,
	input  logic              start,
	input  hfa_pkg::hfa_in_t  in_word,
	output logic              busy,
	output logic              done,
	output hfa_pkg::hfa_out_t out_word
);
	import hfa_pkg::*;

	localparam int IW = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
	localparam int LW = $clog2(MAX_HOLES + 1);

	hfa_state_t state_q, state_d;

	logic [SIZE_W-1:0] mem [MAX_HOLES];
	logic [SIZE_W-1:0] rd_q;
	logic [IW-1:0]     rd_addr;

	logic [LW-1:0]     cnt_q, limit_q;
	logic [SIZE_W-1:0] amt_q, best_q;
	logic [IW-1:0]     pick_q;
	logic              found_q;
	logic [NUM_W-1:0]  req_q;
	logic              done_q;
	hfa_out_t          out_q;

	logic [IW-1:0]     idx;
	logic [SIZE_W:0]   diff;
	logic [SIZE_W-1:0] left;
	logic              fits, take, at_end, is_first, accept, load_ok;

	assign accept   = start && (state_q == ST_IDLE);
	assign load_ok  = 32'(in_word.hole_select) < MAX_HOLES;
	assign idx      = cnt_q[IW-1:0];
	assign at_end   = (cnt_q == limit_q);
	assign is_first = !(cfg.fit_policy == POLICY_BEST || cfg.fit_policy == POLICY_WORST);

	// shared subtract and compare unit, one hole per cycle
	assign diff = {1'b0, rd_q} - {1'b0, amt_q};
	assign fits = !diff[SIZE_W];
	assign left = diff[SIZE_W-1:0];

	always_comb begin
		priority if (cfg.fit_policy == POLICY_BEST)
			take = fits && (!found_q || left < best_q);
		else if (cfg.fit_policy == POLICY_WORST)
			take = fits && (!found_q || left > best_q);
		else
			take = fits;
	end

	// read address runs one hole ahead of the compare
	assign rd_addr = (state_q == ST_SCAN) ? IW'(idx + 1'b1) : '0;

	// hole size table
	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (accept && in_word.kind == KIND_LOAD && load_ok)
			mem[IW'(in_word.hole_select)] <= in_word.amount;
		else if (state_q == ST_UPDATE && found_q)
			mem[pick_q] <= best_q;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_word.kind == KIND_REQUEST)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (at_end || (take && is_first))
					state_d = ST_UPDATE;
			end
			ST_UPDATE: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// scan working registers
	always_ff @(posedge clk) begin
		if (accept && in_word.kind == KIND_REQUEST) begin
			amt_q   <= in_word.amount;
			cnt_q   <= '0;
			found_q <= 1'b0;
			if (32'(cfg.hole_count) > MAX_HOLES)
				limit_q <= LW'(MAX_HOLES);
			else
				limit_q <= LW'(cfg.hole_count);
		end else if (state_q == ST_SCAN && !at_end) begin
			cnt_q <= LW'(cnt_q + 1'b1);
			if (take) begin
				found_q <= 1'b1;
				pick_q  <= idx;
				best_q  <= left;
			end
		end
	end

	// result word and running request number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			req_q  <= '0;
		end else begin
			done_q <= (state_q == ST_UPDATE);
			if (state_q == ST_UPDATE)
				req_q <= NUM_W'(req_q + 1'b1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE) begin
			out_q.request_number <= req_q;
			out_q.granted        <= found_q;
			out_q.chosen_hole    <= found_q ? SEL_W'(pick_q) : '0;
		end
	end

	assign busy     = (state_q != ST_IDLE);
	assign done     = done_q;
	assign out_word = out_q;

endmodule

### rtl/hole_fit_allocator.sv
`timescale 1ns / 1ps
// load word: busy stays low, next word may follow at once
// request word: scan of min(hole_count, MAX_HOLES) holes, one per cycle through one
// subtract and compare unit, then an update state that writes the table; done is registered
// from the update state, and first fit stops early at the first hole that fits
// busy covers scan and update, next word taken once busy is low again; no stall
// reset clears the registers, the request number and the sequencer; hole sizes are not cleared
module hole_fit_allocator #(
	parameter int MAX_HOLES = hfa_pkg::MAX_HOLES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  hfa_pkg::hfa_in_t  in_word,
	output logic              done,
	output hfa_pkg::hfa_out_t out_word,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import hfa_pkg::*;

	hfa_cfg_t cfg;

	// configuration registers
	hfa_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// hole table and scan sequencer
	hfa_scan #(
		.MAX_HOLES (MAX_HOLES)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.start    (start),
		.in_word  (in_word),
		.busy     (busy),
		.done     (done),
		.out_word (out_word)
	);

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import hfa_pkg::*;

	localparam int RAND_ITEMS = 2000;
	localparam int QUIET_TAIL = 200;
	localparam int DRAIN_LAT  = MAX_HOLES_DEF + 6;
	localparam int CYCLE_CAP  = 400000;

	// allocation table mirror and expected grant words
	class alloc_scoreboard;
		logic [POLICY_W-1:0] policy;
		logic [COUNT_W-1:0]  count;
		logic [SIZE_W-1:0]   sizes[MAX_HOLES_DEF];
		logic [NUM_W-1:0]    next_number;
		hfa_out_t            expected_grants[$];
		int                  errors;
		int                  loads;
		int                  requests;
		int                  grants;

		function new();
			policy = POLICY_FIRST;
			count = '0;
			next_number = '0;
			errors = 0;
			loads = 0;
			requests = 0;
			grants = 0;
			foreach (sizes[i]) sizes[i] = '0;
		endfunction

		function void set_reg(logic idx, logic [31:0] value);
			if (idx == REG_POLICY)
				policy = value[POLICY_W-1:0];
			else
				count = value[COUNT_W-1:0];
		endfunction

		function int holes_in_use();
			return (count > MAX_HOLES_DEF) ? MAX_HOLES_DEF : int'(count);
		endfunction

		// accepted input word: load a hole or predict the grant
		function void note_word(hfa_in_t w);
			hfa_out_t r;
			int lim;
			int pick;
			int best_left;
			int left;
			bit found;
			bit stop;
			if (w.kind == KIND_LOAD) begin
				sizes[w.hole_select] = w.amount;
				loads++;
				return;
			end
			lim = holes_in_use();
			pick = 0;
			best_left = 0;
			found = 0;
			stop = 0;
			for (int j = 0; j < lim && !stop; j++) begin
				if (sizes[j] >= w.amount) begin
					left = int'(sizes[j]) - int'(w.amount);
					if (policy == POLICY_BEST) begin
						if (!found || left < best_left) begin
							found = 1;
							pick = j;
							best_left = left;
						end
					end else if (policy == POLICY_WORST) begin
						if (!found || left > best_left) begin
							found = 1;
							pick = j;
							best_left = left;
						end
					end else begin
						// first fit, also the undefined policy code
						found = 1;
						pick = j;
						stop = 1;
					end
				end
			end
			if (found)
				sizes[pick] = sizes[pick] - w.amount;
			r.request_number = next_number;
			r.granted = found;
			r.chosen_hole = found ? pick[SEL_W-1:0] : '0;
			next_number = next_number + 1'b1;
			expected_grants.push_back(r);
			requests++;
			if (found)
				grants++;
		endfunction

		// result word against the oldest expectation
		function void check_result(hfa_out_t got);
			hfa_out_t exp_w;
			if (expected_grants.size() == 0) begin
				$display("%0t: unexpected result word, actual %h", $time, got);
				errors++;
				return;
			end
			exp_w = expected_grants.pop_front();
			if (got.request_number !== exp_w.request_number) begin
				$display("%0t: request_number expected %0d actual %0d",
					$time, exp_w.request_number, got.request_number);
				errors++;
			end
			if (got.granted !== exp_w.granted) begin
				$display("%0t: granted expected %0d actual %0d (request %0d)",
					$time, exp_w.granted, got.granted, exp_w.request_number);
				errors++;
			end
			if (got.chosen_hole !== exp_w.chosen_hole) begin
				$display("%0t: chosen_hole expected %0d actual %0d (request %0d)",
					$time, exp_w.chosen_hole, got.chosen_hole, exp_w.request_number);
				errors++;
			end
		endfunction

		function int pending();
			return expected_grants.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	hfa_in_t     in_word = '0;
	logic        done;
	hfa_out_t    out_word;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	alloc_scoreboard sb = new();
	int cycles = 0;
	int reg_writes = 0;
	int phases = 0;
	int rand_sent = 0;

	hole_fit_allocator dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.in_word (in_word),
		.done    (done),
		.out_word(out_word),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(out_word);
	end

	// cycle cap
	initial begin
		while (cycles < CYCLE_CAP) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_top: done, errors");
		$finish;
	end

	// present one word and hold it until accepted
	task automatic send_word(hfa_in_t w);
		@(negedge clk);
		start <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (busy);
		sb.note_word(w);
	endtask

	task automatic idle_cycles(int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic load_hole(int idx, int size);
		hfa_in_t w;
		w.kind = KIND_LOAD;
		w.hole_select = idx[SEL_W-1:0];
		w.amount = size[SIZE_W-1:0];
		send_word(w);
	endtask

	task automatic request(int amt);
		hfa_in_t w;
		w.kind = KIND_REQUEST;
		w.hole_select = SEL_W'($urandom);
		w.amount = amt[SIZE_W-1:0];
		send_word(w);
	endtask

	// wait until every grant is back, then let the sequencer settle
	task automatic drain();
		idle_cycles(1);
		while (sb.pending() > 0) @(posedge clk);
		repeat (DRAIN_LAT) @(posedge clk);
	endtask

	// apb write, setup then access
	task automatic reg_write(logic idx, int value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, value);
		reg_writes++;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	function automatic int pick_size();
		case ($urandom_range(0, 9))
			0, 1: return $urandom_range(0, 65535);
			2: return ($urandom_range(0, 1) != 0) ? 65535 : 0;
			3: return int'(sb.sizes[$urandom_range(0, MAX_HOLES_DEF - 1)]);
			default: return $urandom_range(0, 5000);
		endcase
	endfunction

	function automatic int pick_amount();
		int lim;
		int s;
		lim = sb.holes_in_use();
		s = (lim > 0) ? int'(sb.sizes[$urandom_range(0, lim - 1)]) : 0;
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 65535;
			2: return s;
			3: return (s < 65535) ? s + 1 : s;
			4, 5, 6, 7: return $urandom_range(1, 2000);
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	function automatic int pick_count();
		case ($urandom_range(0, 7))
			0: return 0;
			1: return MAX_HOLES_DEF;
			2: return 31;
			3: return $urandom_range(MAX_HOLES_DEF + 1, 31);
			4: return 1;
			default: return $urandom_range(1, MAX_HOLES_DEF);
		endcase
	endfunction

	initial begin
		int n_items;
		int quiet;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed: fill every hole before any request reads one
		reg_write(REG_POLICY, POLICY_FIRST);
		reg_write(REG_COUNT, MAX_HOLES_DEF);
		load_hole(0, 0);
		load_hole(1, 65535);
		load_hole(2, 100);
		load_hole(3, 100);
		load_hole(4, 200);
		load_hole(5, 16'haaaa);
		load_hole(6, 16'h5555);
		load_hole(7, 1);
		for (int i = 8; i < MAX_HOLES_DEF; i++)
			load_hole(i, 1000 * i);
		// zero amount takes hole 0, full amount empties hole 1
		request(0);
		request(65535);
		request(50000);
		drain();
		// best fit tie between equal holes, then worst fit
		reg_write(REG_POLICY, POLICY_BEST);
		request(100);
		drain();
		reg_write(REG_POLICY, POLICY_WORST);
		request(100);
		drain();
		// undefined policy code falls back to first fit
		reg_write(REG_POLICY, 3);
		request(1);
		drain();
		// no holes in use
		reg_write(REG_COUNT, 0);
		request(5);
		drain();
		// oversized count saturates
		reg_write(REG_COUNT, 31);
		request(1);
		drain();
		// single hole, no fit
		reg_write(REG_COUNT, 1);
		request(65535);
		drain();

		// random phases
		while (rand_sent < RAND_ITEMS) begin
			phases++;
			reg_write(REG_POLICY, $urandom_range(0, 3));
			reg_write(REG_COUNT, pick_count());
			n_items = $urandom_range(20, 60);
			for (int k = 0; k < n_items && rand_sent < RAND_ITEMS; k++) begin
				quiet = (rand_sent >= RAND_ITEMS - QUIET_TAIL);
				if (!quiet && $urandom_range(0, 5) == 0)
					idle_cycles($urandom_range(1, 18));
				// hold off once until every grant has come back
				if (phases == 3 && k == n_items / 2) begin
					idle_cycles(1);
					while (sb.pending() > 0) @(posedge clk);
				end
				if ($urandom_range(0, 9) < 3)
					load_hole($urandom_range(0, MAX_HOLES_DEF - 1), pick_size());
				else
					request(pick_amount());
				rand_sent++;
			end
			drain();
		end

		drain();
		if (sb.pending() != 0) begin
			$display("%0t: result words expected %0d actual 0", $time, sb.pending());
			sb.errors++;
		end
		$display("tb_top: %0d loads, %0d requests, %0d granted, %0d register writes",
			sb.loads, sb.requests, sb.grants, reg_writes);
		$display("tb_top: all four policy codes, hole counts 0 to 31, %0d random phases",
			phases);
		if (sb.errors == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule
